// ===== rtl/core/bta_pkg.sv =====
// ----------------------------------------------------------------------------
// Boundary-tag allocator package
// Shared constants for the first-fit boundary-tag heap manager.
// ----------------------------------------------------------------------------
package bta_pkg;

   localparam int DEF_HEAP_BYTES = 65536;

   localparam int TAG_W    = 17;
   localparam int SIZE_W   = 17;
   localparam int REQ_W    = 17;
   localparam int ADDR_W   = 16;
   localparam int STAT_W   = 2;
   localparam int LIMIT_W  = 17;

   localparam int FIRST_BP      = 16;
   localparam int ALIGN_BYTES   = 8;
   localparam int MIN_BLOCK     = 16;

   localparam logic [TAG_W-1:0]   PROLOGUE_TAG = TAG_W'(9);
   localparam logic [TAG_W-1:0]   EPILOGUE_TAG = TAG_W'(1);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(65536);

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NULL = 2'd1;
   localparam logic [STAT_W-1:0] STAT_OOM  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_BAD  = 2'd3;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

endpackage

// ===== rtl/core/boundary_tag_first_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// Boundary-tag first-fit allocator
// Heap manager over a tag store of header and footer words.
// ----------------------------------------------------------------------------
// Flow: a first-fit walk visits block headers, then tag writes and neighbour
//   reads follow, and the response is registered before it is output.
// Throughput: one item at a time; the single tag RAM port pair sets the pace.
// Reset: synchronous; tag init (prologue, epilogue) follows, with req_tready
//   low. Break offset returns to 16, heap_limit to 65536.
module boundary_tag_first_fit_allocator
   import bta_pkg::*;
#(
   parameter int HEAP_BYTES = DEF_HEAP_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // request_size[16:0], free_address[32:17]
   input  logic                  req_tuser,  // kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // block_address[15:0], granted_size[32:16],
                                             // status[34:33]
   input  logic                  csr_wen,
   input  logic [LIMIT_W-1:0]    csr_wdata
);

   localparam int DEPTH  = HEAP_BYTES / 4;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int OFF_W  = ($clog2(HEAP_BYTES) + 2 > 18) ? $clog2(HEAP_BYTES) + 2 : 18;

   localparam logic [3:0] ST_INIT  = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_WRD   = 4'd2;
   localparam logic [3:0] ST_WCHK  = 4'd3;
   localparam logic [3:0] ST_GROW  = 4'd4;
   localparam logic [3:0] ST_GEPI  = 4'd5;
   localparam logic [3:0] ST_GMRG  = 4'd6;
   localparam logic [3:0] ST_SBH   = 4'd7;
   localparam logic [3:0] ST_SBF   = 4'd8;
   localparam logic [3:0] ST_PLACE = 4'd9;
   localparam logic [3:0] ST_SPLIT = 4'd10;
   localparam logic [3:0] ST_FRP   = 4'd11;
   localparam logic [3:0] ST_FRN   = 4'd12;
   localparam logic [3:0] ST_FMRG  = 4'd13;
   localparam logic [3:0] ST_DONE  = 4'd14;

   localparam logic [OFF_W-1:0] OFF_FIRST = OFF_W'(FIRST_BP);
   localparam logic [OFF_W-1:0] OFF_HEAP  = OFF_W'(HEAP_BYTES);

   logic [3:0]         state_ff, state_in;
   logic [1:0]         init_cnt_ff, init_cnt_in;
   logic [OFF_W-1:0]   brk_ff, brk_in;
   logic [LIMIT_W-1:0] limit_ff;
   logic               kind_ff, kind_in;
   logic [SIZE_W-1:0]  need_ff, need_in;
   logic [ADDR_W-1:0]  fa_ff, fa_in;
   logic [OFF_W-1:0]   bp_ff, bp_in;
   logic [OFF_W-1:0]   found_ff, found_in;
   logic [SIZE_W-1:0]  fsz_ff, fsz_in;
   logic [SIZE_W-1:0]  psz_ff, psz_in;
   logic               pused_ff, pused_in;
   logic [OFF_W-1:0]   sb_bp_ff, sb_bp_in;
   logic [SIZE_W-1:0]  sb_sz_ff, sb_sz_in;
   logic               sb_used_ff, sb_used_in;
   logic [3:0]         sb_ret_ff, sb_ret_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;
   logic [SIZE_W-1:0]  res_gsize_ff, res_gsize_in;
   logic [STAT_W-1:0]  res_stat_ff, res_stat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic               wr_en, rd_en;
   logic [OFF_W-1:0]   wr_off, rd_off;
   logic [TAG_W-1:0]   wr_data, rd_data;

   logic [REQ_W-1:0]   req_size;
   logic [ADDR_W-1:0]  req_fa;
   logic [REQ_W:0]     req_round;
   logic [SIZE_W-1:0]  need_calc;
   logic [SIZE_W-1:0]  rd_sz;
   logic               rd_used;
   logic [OFF_W-1:0]   lim;
   logic [OFF_W-1:0]   fa_off;
   logic [OFF_W-1:0]   sum3;

   assign req_size  = req_tdata[REQ_W-1:0];
   assign req_fa    = req_tdata[REQ_W+ADDR_W-1:REQ_W];
   assign req_round = {1'b0, req_size} + (REQ_W+1)'(ALIGN_BYTES - 1);
   assign need_calc = (req_size < REQ_W'(ALIGN_BYTES)) ? SIZE_W'(MIN_BLOCK)
                    : SIZE_W'(ALIGN_BYTES) + SIZE_W'({req_round[REQ_W:3], 3'b000});
   assign rd_sz     = {rd_data[TAG_W-1:3], 3'b000};
   assign rd_used   = rd_data[0];
   assign lim       = ({{(OFF_W-LIMIT_W){1'b0}}, limit_ff} > OFF_HEAP) ? OFF_HEAP
                    : OFF_W'(limit_ff);
   assign fa_off    = OFF_W'(fa_ff);
   assign sum3      = OFF_W'(fsz_ff) + OFF_W'(psz_ff) + OFF_W'(rd_sz);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   bta_ram #(
      .WIDTH (TAG_W),
      .DEPTH (DEPTH)
   ) u_tags (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_off[IDX_W+1:2]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_off[IDX_W+1:2]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      init_cnt_in  = init_cnt_ff;
      brk_in       = brk_ff;
      kind_in      = kind_ff;
      need_in      = need_ff;
      fa_in        = fa_ff;
      bp_in        = bp_ff;
      found_in     = found_ff;
      fsz_in       = fsz_ff;
      psz_in       = psz_ff;
      pused_in     = pused_ff;
      sb_bp_in     = sb_bp_ff;
      sb_sz_in     = sb_sz_ff;
      sb_used_in   = sb_used_ff;
      sb_ret_in    = sb_ret_ff;
      res_addr_in  = res_addr_ff;
      res_gsize_in = res_gsize_ff;
      res_stat_in  = res_stat_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_off       = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_off       = '0;

      unique case (state_ff)
         ST_INIT: begin
            wr_en       = 1'b1;
            wr_off      = OFF_W'({init_cnt_ff, 2'b00}) + OFF_W'(4);
            wr_data     = (init_cnt_ff == 2'd2) ? EPILOGUE_TAG : PROLOGUE_TAG;
            init_cnt_in = init_cnt_ff + 2'd1;
            if (init_cnt_ff == 2'd2) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in      = req_tuser;
               need_in      = need_calc;
               fa_in        = req_fa;
               bp_in        = OFF_FIRST;
               res_addr_in  = '0;
               res_gsize_in = '0;
               res_stat_in  = STAT_OK;
               if ((req_tuser == KIND_ALLOC && req_size == '0) ||
                   (req_tuser == KIND_FREE && req_fa == '0)) begin
                  res_stat_in = STAT_NULL;
                  state_in    = ST_DONE;
               end else begin
                  state_in = ST_WRD;
               end
            end
         end
         ST_WRD: begin
            if (bp_ff < brk_ff && (kind_ff == KIND_ALLOC || bp_ff <= fa_off)) begin
               rd_en    = 1'b1;
               rd_off   = bp_ff - OFF_W'(4);
               state_in = ST_WCHK;
            end else if (kind_ff == KIND_ALLOC) begin
               state_in = ST_GROW;
            end else begin
               res_stat_in = STAT_BAD;
               state_in    = ST_DONE;
            end
         end
         ST_WCHK: begin
            bp_in = bp_ff + OFF_W'(rd_sz);
            priority if (rd_sz == '0) begin
               bp_in = bp_ff;
               if (kind_ff == KIND_ALLOC) begin
                  state_in = ST_GROW;
               end else begin
                  res_stat_in = STAT_BAD;
                  state_in    = ST_DONE;
               end
            end else if (kind_ff == KIND_ALLOC) begin
               if (!rd_used && rd_sz >= need_ff) begin
                  bp_in    = bp_ff;
                  found_in = bp_ff;
                  fsz_in   = rd_sz;
                  state_in = ST_PLACE;
               end else begin
                  state_in = ST_WRD;
               end
            end else if (bp_ff == fa_off) begin
               bp_in = bp_ff;
               if (rd_used) begin
                  fsz_in     = rd_sz;
                  sb_bp_in   = bp_ff;
                  sb_sz_in   = rd_sz;
                  sb_used_in = 1'b0;
                  sb_ret_in  = ST_FRP;
                  state_in   = ST_SBH;
               end else begin
                  res_stat_in = STAT_BAD;
                  state_in    = ST_DONE;
               end
            end else begin
               state_in = ST_WRD;
            end
         end
         ST_GROW: begin
            if (brk_ff + OFF_W'(need_ff) > lim) begin
               res_stat_in = STAT_OOM;
               state_in    = ST_DONE;
            end else begin
               bp_in      = brk_ff;
               brk_in     = brk_ff + OFF_W'(need_ff);
               sb_bp_in   = brk_ff;
               sb_sz_in   = need_ff;
               sb_used_in = 1'b0;
               sb_ret_in  = ST_GEPI;
               state_in   = ST_SBH;
            end
         end
         ST_GEPI: begin
            wr_en    = 1'b1;
            wr_off   = brk_ff - OFF_W'(4);
            wr_data  = EPILOGUE_TAG;
            rd_en    = 1'b1;
            rd_off   = bp_ff - OFF_W'(8);
            state_in = ST_GMRG;
         end
         ST_GMRG: begin
            if (rd_used) begin
               found_in = bp_ff;
               fsz_in   = need_ff;
               state_in = ST_PLACE;
            end else begin
               found_in   = bp_ff - OFF_W'(rd_sz);
               fsz_in     = need_ff + rd_sz;
               sb_bp_in   = bp_ff - OFF_W'(rd_sz);
               sb_sz_in   = need_ff + rd_sz;
               sb_used_in = 1'b0;
               sb_ret_in  = ST_PLACE;
               state_in   = ST_SBH;
            end
         end
         ST_SBH: begin
            wr_en    = 1'b1;
            wr_off   = sb_bp_ff - OFF_W'(4);
            wr_data  = {sb_sz_ff[SIZE_W-1:1], sb_used_ff};
            state_in = ST_SBF;
         end
         ST_SBF: begin
            wr_en    = 1'b1;
            wr_off   = sb_bp_ff + OFF_W'(sb_sz_ff) - OFF_W'(8);
            wr_data  = {sb_sz_ff[SIZE_W-1:1], sb_used_ff};
            state_in = sb_ret_ff;
         end
         ST_PLACE: begin
            res_addr_in = found_ff[ADDR_W-1:0];
            sb_bp_in    = found_ff;
            sb_used_in  = 1'b1;
            state_in    = ST_SBH;
            if (fsz_ff - need_ff >= SIZE_W'(MIN_BLOCK)) begin
               res_gsize_in = need_ff;
               sb_sz_in     = need_ff;
               sb_ret_in    = ST_SPLIT;
            end else begin
               res_gsize_in = fsz_ff;
               sb_sz_in     = fsz_ff;
               sb_ret_in    = ST_DONE;
            end
         end
         ST_SPLIT: begin
            sb_bp_in   = found_ff + OFF_W'(need_ff);
            sb_sz_in   = fsz_ff - need_ff;
            sb_used_in = 1'b0;
            sb_ret_in  = ST_DONE;
            state_in   = ST_SBH;
         end
         ST_FRP: begin
            rd_en    = 1'b1;
            rd_off   = bp_ff - OFF_W'(8);
            state_in = ST_FRN;
         end
         ST_FRN: begin
            psz_in   = rd_sz;
            pused_in = rd_used;
            rd_en    = 1'b1;
            rd_off   = bp_ff + OFF_W'(fsz_ff) - OFF_W'(4);
            state_in = ST_FMRG;
         end
         ST_FMRG: begin
            sb_used_in = 1'b0;
            sb_ret_in  = ST_DONE;
            priority if (pused_ff && rd_used) begin
               state_in = ST_DONE;
            end else if (pused_ff) begin
               sb_bp_in = bp_ff;
               sb_sz_in = fsz_ff + rd_sz;
               state_in = ST_SBH;
            end else if (rd_used) begin
               sb_bp_in = bp_ff - OFF_W'(psz_ff);
               sb_sz_in = fsz_ff + psz_ff;
               state_in = ST_SBH;
            end else begin
               sb_bp_in = bp_ff - OFF_W'(psz_ff);
               sb_sz_in = sum3[SIZE_W-1:0];
               state_in = ST_SBH;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({res_stat_ff, res_gsize_ff, res_addr_ff});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_cnt_ff  <= '0;
         brk_ff       <= OFF_FIRST;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         brk_ff       <= brk_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      need_ff      <= need_in;
      fa_ff        <= fa_in;
      bp_ff        <= bp_in;
      found_ff     <= found_in;
      fsz_ff       <= fsz_in;
      psz_ff       <= psz_in;
      pused_ff     <= pused_in;
      sb_bp_ff     <= sb_bp_in;
      sb_sz_ff     <= sb_sz_in;
      sb_used_ff   <= sb_used_in;
      sb_ret_ff    <= sb_ret_in;
      res_addr_ff  <= res_addr_in;
      res_gsize_ff <= res_gsize_in;
      res_stat_ff  <= res_stat_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

// ===== rtl/core/bta_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bta_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bta_checker.sv =====
// ----------------------------------------------------------------------------
// Boundary-tag allocator checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bta_checker
   import bta_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [ADDR_W-1:0] addr;
   logic [SIZE_W-1:0] gsize;
   logic [STAT_W-1:0] stat;

   assign addr  = rsp_tdata[ADDR_W-1:0];
   assign gsize = rsp_tdata[ADDR_W+SIZE_W-1:ADDR_W];
   assign stat  = rsp_tdata[ADDR_W+SIZE_W+STAT_W-1:ADDR_W+SIZE_W];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("item dropped or changed under stall");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && stat != STAT_OK |-> addr == '0 && gsize == '0)
      else $error("failed item carries address or size");

   a_grant_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && gsize != '0 |->
         gsize >= SIZE_W'(MIN_BLOCK) && gsize[2:0] == 3'b000 &&
         addr[2:0] == 3'b000 && addr >= ADDR_W'(FIRST_BP))
      else $error("granted block misaligned or undersized");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("activity straight after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("new item taken while busy");

endmodule

bind boundary_tag_first_fit_allocator bta_checker u_bta_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Boundary-tag first-fit allocator testbench
// A table of directed requests is followed by phases of random allocate and
// free traffic under several heap limits. Every response is checked against
// a predictor of the heap kept in the bench, or against the fixed response of a directed row.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bta_pkg::*;

   localparam int TAGS      = DEF_HEAP_BYTES / 4;
   localparam int WDOG_MAX  = 50000;
   localparam int DRAIN     = 40;
   localparam int LONG_HOLD = 2000;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] gsize;
      logic [STAT_W-1:0] status;
   } heap_rsp_type;

   typedef struct {
      logic              kind;
      logic [REQ_W-1:0]  size;
      logic [ADDR_W-1:0] faddr;
      int                live_idx;   // >= 0: free that live block instead
      bit                fixed;
      heap_rsp_type      rsp;
   } dir_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wen = 1'b0;
   logic [LIMIT_W-1:0]    csr_wdata = '0;

   boundary_tag_first_fit_allocator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // heap predictor state
   logic [31:0]       tags [0:TAGS-1];
   int unsigned       brk;
   int unsigned       limit;
   logic [ADDR_W-1:0] live [$];
   heap_rsp_type      rsp_due [$];
   int                errors = 0;
   int                rsp_count = 0;
   int                idle_cycles = 0;

   // item on offer, read by the monitor at acceptance
   bit                offer_fixed = 0;
   heap_rsp_type      offer_rsp;

   function automatic logic [31:0] tag_rd(int unsigned b);
      return ((b >> 2) < TAGS) ? tags[b >> 2] : 32'd0;
   endfunction

   function automatic void tag_wr(int unsigned b, logic [31:0] v);
      if ((b >> 2) < TAGS) tags[b >> 2] = v;
   endfunction

   function automatic int unsigned bsize(int unsigned bp);
      return tag_rd(bp - 4) & 32'hFFFF_FFF8;
   endfunction

   function automatic bit bused(int unsigned bp);
      return (tag_rd(bp - 4) & 32'd1) != 32'd0;
   endfunction

   function automatic void set_blk(int unsigned bp, int unsigned sz, bit used);
      tag_wr(bp - 4, sz | used);
      tag_wr(bp + sz - 8, sz | used);
   endfunction

   function automatic int unsigned coalesce(int unsigned bp);
      int unsigned sz, ptag, nbp, psz, nsz;
      bit pu, nu;
      sz = bsize(bp);
      ptag = tag_rd(bp - 8);
      nbp = bp + sz;
      pu = ptag[0];
      nu = bused(nbp);
      psz = ptag & 32'hFFFF_FFF8;
      nsz = bsize(nbp);
      if (pu && nu) return bp;
      if (pu) begin
         set_blk(bp, sz + nsz, 0);
         return bp;
      end
      if (nu) begin
         set_blk(bp - psz, sz + psz, 0);
         return bp - psz;
      end
      set_blk(bp - psz, sz + psz + nsz, 0);
      return bp - psz;
   endfunction

   function automatic void heap_init();
      foreach (tags[i]) tags[i] = 0;
      tag_wr(4, 32'(PROLOGUE_TAG));
      tag_wr(8, 32'(PROLOGUE_TAG));
      tag_wr(12, 32'(EPILOGUE_TAG));
      brk = FIRST_BP;
      limit = 32'(LIMIT_RESET);
   endfunction

   function automatic heap_rsp_type heap_apply(logic kind, int unsigned req,
                                               int unsigned fa);
      heap_rsp_type r;
      int unsigned need, bp, found, lim, orig;
      bit ok;
      r = '0;
      found = 0;
      if (kind == KIND_ALLOC) begin
         if (req == 0) begin
            r.status = STAT_NULL;
         end else begin
            need = (req < ALIGN_BYTES) ? MIN_BLOCK : ALIGN_BYTES + ((req + 7) & ~32'd7);
            bp = FIRST_BP;
            while (bp < brk && bsize(bp) > 0) begin
               if (!bused(bp) && bsize(bp) >= need) begin
                  found = bp;
                  break;
               end
               bp += bsize(bp);
            end
            if (found == 0) begin
               lim = (limit > DEF_HEAP_BYTES) ? DEF_HEAP_BYTES : limit;
               if (brk + need > lim) begin
                  r.status = STAT_OOM;
               end else begin
                  bp = brk;
                  brk += need;
                  set_blk(bp, need, 0);
                  tag_wr(bp + need - 4, 1);
                  found = coalesce(bp);
               end
            end
            if (found != 0) begin
               orig = bsize(found);
               if (orig - need >= MIN_BLOCK) begin
                  set_blk(found, need, 1);
                  set_blk(found + need, orig - need, 0);
                  r.gsize = SIZE_W'(need);
               end else begin
                  set_blk(found, orig, 1);
                  r.gsize = SIZE_W'(orig);
               end
               r.addr = ADDR_W'(found);
               live.push_back(ADDR_W'(found));
            end
         end
      end else if (fa == 0) begin
         r.status = STAT_NULL;
      end else begin
         ok = 0;
         bp = FIRST_BP;
         while (bp < brk && bsize(bp) > 0 && bp <= fa) begin
            if (bp == fa) begin
               ok = bused(bp);
               break;
            end
            bp += bsize(bp);
         end
         if (!ok) begin
            r.status = STAT_BAD;
         end else begin
            set_blk(fa, bsize(fa), 0);
            void'(coalesce(fa));
            foreach (live[i]) if (live[i] == fa) begin
               live.delete(i);
               break;
            end
         end
      end
      return r;
   endfunction

   // monitor, predictor and watchdog
   always @(posedge clock) begin
      heap_rsp_type e, a;
      bit moved;
      moved = 0;
      if (reset) begin
         heap_init();
      end else begin
         if (csr_wen) limit = 32'(csr_wdata);
         if (req_tvalid && req_tready) begin
            e = heap_apply(req_tuser, 32'(req_tdata[16:0]), 32'(req_tdata[32:17]));
            rsp_due.push_back(offer_fixed ? offer_rsp : e);
            moved = 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            a.addr = rsp_tdata[15:0];
            a.gsize = rsp_tdata[32:16];
            a.status = rsp_tdata[34:33];
            rsp_count++;
            moved = 1;
            if (rsp_due.size() == 0) begin
               $error("response item with nothing expected");
               errors++;
            end else begin
               e = rsp_due.pop_front();
               if (a.addr !== e.addr) begin
                  $error("block_address expected %0d got %0d", e.addr, a.addr);
                  errors++;
               end
               if (a.gsize !== e.gsize) begin
                  $error("granted_size expected %0d got %0d", e.gsize, a.gsize);
                  errors++;
               end
               if (a.status !== e.status) begin
                  $error("status expected %0d got %0d", e.status, a.status);
                  errors++;
               end
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WDOG_MAX) begin
            $display("boundary_tag_first_fit_allocator test failed");
            $finish;
         end
      end
   end

   // receiver: shifting stall pattern plus one long hold-off
   initial begin
      int mode, left, hold;
      bit held;
      mode = 0; left = 0; hold = 0; held = 0;
      forever begin
         @(negedge clock);
         if (!held && rsp_count >= 200) begin
            held = 1;
            hold = LONG_HOLD;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 2);
            left = $urandom_range(10, 80);
         end
         left--;
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   task automatic offer(logic kind, logic [REQ_W-1:0] size, logic [ADDR_W-1:0] fa,
                        bit fixed, heap_rsp_type r);
      offer_fixed = fixed;
      offer_rsp = r;
      req_tuser <= kind;
      req_tdata <= {7'd0, fa, size};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic pause(int n);
      req_tvalid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic set_limit(logic [LIMIT_W-1:0] v);
      pause(0);
      while (rsp_due.size() != 0) @(negedge clock);
      pause(DRAIN);
      csr_wen <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   function automatic logic [ADDR_W-1:0] pick_live(int unsigned idx);
      if (live.size() == 0) return 16'hFFFF;
      return live[idx % live.size()];
   endfunction

   function automatic dir_row_type row(logic kind, int size, int fa, int li, bit fixed,
                                       int ad, int gs, logic [STAT_W-1:0] st);
      dir_row_type d;
      d.kind = kind; d.size = REQ_W'(size); d.faddr = ADDR_W'(fa);
      d.live_idx = li; d.fixed = fixed;
      d.rsp.addr = ADDR_W'(ad); d.rsp.gsize = SIZE_W'(gs); d.rsp.status = st;
      return d;
   endfunction

   // sender
   initial begin
      dir_row_type dir_tab [$];
      logic [LIMIT_W-1:0] phase_lim [4];
      int burst, r;
      logic kind;
      logic [REQ_W-1:0] sz;
      logic [ADDR_W-1:0] fa;

      phase_lim = '{17'h1FFFF, 17'd16, 17'd2048, 17'd65536};
      dir_tab.push_back(row(KIND_ALLOC, 0, 0, -1, 1, 0, 0, STAT_NULL));
      dir_tab.push_back(row(KIND_FREE, 0, 0, -1, 1, 0, 0, STAT_NULL));
      dir_tab.push_back(row(KIND_ALLOC, 1, 0, -1, 1, 16, 16, STAT_OK));
      dir_tab.push_back(row(KIND_FREE, 0, 8, -1, 1, 0, 0, STAT_BAD));
      dir_tab.push_back(row(KIND_FREE, 0, 0, 0, 0, 0, 0, STAT_OK));
      dir_tab.push_back(row(KIND_FREE, 0, 16, -1, 1, 0, 0, STAT_BAD));
      dir_tab.push_back(row(KIND_ALLOC, 65536, 0, -1, 1, 0, 0, STAT_OOM));
      dir_tab.push_back(row(KIND_ALLOC, 7, 0, -1, 0, 0, 0, STAT_OK));
      dir_tab.push_back(row(KIND_ALLOC, 8, 0, -1, 0, 0, 0, STAT_OK));
      dir_tab.push_back(row(KIND_ALLOC, 9, 0, -1, 0, 0, 0, STAT_OK));
      dir_tab.push_back(row(KIND_ALLOC, 24, 0, -1, 0, 0, 0, STAT_OK));
      dir_tab.push_back(row(KIND_ALLOC, 100, 0, -1, 0, 0, 0, STAT_OK));
      dir_tab.push_back(row(KIND_FREE, 0, 16'hFFFF, -1, 1, 0, 0, STAT_BAD));
      dir_tab.push_back(row(KIND_FREE, 0, 0, 1, 0, 0, 0, STAT_OK));
      dir_tab.push_back(row(KIND_FREE, 0, 0, 2, 0, 0, 0, STAT_OK));
      dir_tab.push_back(row(KIND_FREE, 0, 0, 0, 0, 0, 0, STAT_OK));
      dir_tab.push_back(row(KIND_ALLOC, 1000, 0, -1, 0, 0, 0, STAT_OK));
      dir_tab.push_back(row(KIND_ALLOC, 16, 0, -1, 0, 0, 0, STAT_OK));
      dir_tab.push_back(row(KIND_FREE, 0, 0, 0, 0, 0, 0, STAT_OK));
      dir_tab.push_back(row(KIND_ALLOC, 8, 0, -1, 0, 0, 0, STAT_OK));
      dir_tab.push_back(row(KIND_ALLOC, 65535, 0, -1, 0, 0, 0, STAT_OK));

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      set_limit(17'd65536);

      foreach (dir_tab[i]) begin
         fa = (dir_tab[i].live_idx >= 0) ? pick_live(dir_tab[i].live_idx)
                                         : dir_tab[i].faddr;
         offer(dir_tab[i].kind, dir_tab[i].size, fa, dir_tab[i].fixed, dir_tab[i].rsp);
      end

      foreach (phase_lim[p]) begin
         set_limit(phase_lim[p]);
         for (int n = 0; n < 150; ) begin
            burst = $urandom_range(1, 20);
            repeat (burst) begin
               r = $urandom_range(0, 99);
               kind = (r < 60) ? KIND_ALLOC : KIND_FREE;
               sz = 0;
               fa = 0;
               if (r < 50) sz = REQ_W'($urandom_range(1, 120));
               else if (r < 57) sz = REQ_W'($urandom_range(0, 65536));
               else if (r < 60) sz = 0;
               else if (r < 85) fa = pick_live($urandom);
               else if (r < 93) fa = ADDR_W'($urandom_range(0, 65535));
               else if (r < 96) fa = ADDR_W'(pick_live($urandom) + 16'd8);
               offer(kind, sz, fa, 0, '0);
               n++;
            end
            if ($urandom_range(0, 3) != 0) pause($urandom_range(0, 6));
         end
      end

      pause(0);
      while (rsp_due.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      if (errors == 0)
         $display("boundary_tag_first_fit_allocator test passed");
      else
         $display("boundary_tag_first_fit_allocator test failed");
      $finish;
   end

endmodule

// ===== boundary_tag_first_fit_allocator.f =====
rtl/core/bta_pkg.sv
rtl/core/bta_ram.sv
rtl/core/boundary_tag_first_fit_allocator.sv
rtl/core/bta_checker.sv
tb/sv/tb.sv
